/* hdl/prbv_pkg.sv */
// Shared types and constants for the PCM ring buffer with volume.
`timescale 1ns / 1ps
`default_nettype none

package prbv_pkg;

  // Field widths that the interface fixes.
  localparam int SAMPLE_W = 32;
  localparam int PCM_W    = 16;
  localparam int LEVEL_W  = 14;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;

  // Gain of 128 passes samples unchanged.
  localparam logic [CFG_W-1:0] FULL_GAIN = 8'd128;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_CNT_W = 2;

  // Command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_ENABLE = 1'd1;

  // One input request.
  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       mono;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic signed [PCM_W-1:0] left_out;
    logic signed [PCM_W-1:0] right_out;
    logic                    underrun;
    logic                    dropped;
    logic [LEVEL_W-1:0]      fill_level;
  } out_item_t;

  // A classified request after sample conversion.
  typedef struct packed {
    logic                    is_pop;
    logic signed [PCM_W-1:0] left_pcm;
    logic signed [PCM_W-1:0] right_pcm;
  } fe_item_t;

endpackage

`default_nettype wire

/* hdl/prbv_front.sv */
// Front end: accepts requests, classifies them and converts samples to 16-bit PCM.
`timescale 1ns / 1ps
`default_nettype none

module prbv_front import prbv_pkg::*; #(
  parameter int FRACTION_BITS = 28
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          fe_valid,
  output fe_item_t      fe_data,
  input  wire logic     fe_ready
);

  localparam logic signed [SAMPLE_W:0] ROUND_ADD = (SAMPLE_W+1)'(1) <<< (FRACTION_BITS - 16);
  localparam logic signed [SAMPLE_W:0] CLIP_HI   =
    ((SAMPLE_W+1)'(1) <<< FRACTION_BITS) - (SAMPLE_W+1)'(1);
  localparam logic signed [SAMPLE_W:0] CLIP_LO   = -((SAMPLE_W+1)'(1) <<< FRACTION_BITS);

  logic     valid_r;
  fe_item_t item_r;
  fe_item_t item_nxt;
  logic     take;

  // Round, clip and narrow one fixed-point sample.
  function automatic logic signed [PCM_W-1:0] to_pcm16(logic signed [SAMPLE_W-1:0] x);
    logic signed [SAMPLE_W:0] s;
    s = $signed({x[SAMPLE_W-1], x}) + ROUND_ADD;
    if (s > CLIP_HI) begin
      s = CLIP_HI;
    end else if (s < CLIP_LO) begin
      s = CLIP_LO;
    end
    return s[FRACTION_BITS -: PCM_W];
  endfunction

  // Conversion of the incoming request; mono copies left into right.
  always_comb begin
    item_nxt.is_pop    = (in_data.cmd == CMD_POP);
    item_nxt.left_pcm  = to_pcm16(in_data.left_sample);
    item_nxt.right_pcm = in_data.mono ? item_nxt.left_pcm : to_pcm16(in_data.right_sample);
  end

  assign in_stall = valid_r && !fe_ready;
  assign take     = in_valid && !in_stall;
  assign fe_valid = valid_r;
  assign fe_data  = item_r;

  // Stage register toward the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (fe_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/prbv_queue.sv */
// Short queue of classified requests between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module prbv_queue import prbv_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  input  wire fe_item_t push_data,
  output logic          push_ready,
  output logic          pop_valid,
  output fe_item_t      pop_data,
  input  wire logic     pop_ready
);

  fe_item_t                 entry_r [QUEUE_DEPTH];
  logic                     wr_ptr_r;
  logic                     rd_ptr_r;
  logic [QUEUE_CNT_W-1:0]   count_r;
  logic                     do_push;
  logic                     do_pop;

  assign push_ready = (count_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hdl/prbv_back.sv */
// Back end: ring pointers, frame memory, overwrite on full and volume scaling.
`timescale 1ns / 1ps
`default_nettype none

module prbv_back import prbv_pkg::*; #(
  parameter int RING_FRAMES = 16384
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire fe_item_t         q_data,
  output logic                  q_ready,
  input  wire logic [CFG_W-1:0] volume,
  input  wire logic             play_enable,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  wire logic             out_stall
);

  localparam int PW = $clog2(2 * RING_FRAMES);
  localparam int AW = $clog2(RING_FRAMES);
  localparam logic [PW:0] PTR_MOD = (PW+1)'(2 * RING_FRAMES);
  localparam logic [PW:0] RING    = (PW+1)'(RING_FRAMES);
  localparam logic [PW:0] HALF    = (PW+1)'(RING_FRAMES / 2);
  localparam int PROD_W = PCM_W + CFG_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCALE
  } state_t;

  state_t                     state_r;
  logic [PW-1:0]              wp_r;
  logic [PW-1:0]              rp_r;
  logic                       out_valid_r;
  out_item_t                  out_data_r;
  logic signed [PROD_W-1:0]   prod_l_r;
  logic signed [PROD_W-1:0]   prod_r_r;
  logic [2*PCM_W-1:0]         mem [RING_FRAMES];
  logic [2*PCM_W-1:0]         rd_data_r;

  logic                       out_free;
  logic                       take;
  logic                       out_load;
  logic                       mem_we;
  logic [PW-1:0]              wp_inc;
  logic [PW-1:0]              fill_cur;
  logic [PW-1:0]              fill_push;
  logic [PW-1:0]              rp_drop;
  logic                       drop;
  logic [PW-1:0]              fill_after_push;
  logic signed [CFG_W:0]      gain;

  // Increment modulo twice the ring size.
  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    logic [PW:0] t;
    t = {1'b0, p} + 1'b1;
    if (t == PTR_MOD) begin
      t = '0;
    end
    return t[PW-1:0];
  endfunction

  // Difference modulo twice the ring size.
  function automatic logic [PW-1:0] ptr_sub(logic [PW-1:0] a, logic [PW-1:0] b);
    logic [PW:0] t;
    t = {1'b0, a} - {1'b0, b};
    if (t[PW]) begin
      t = t + PTR_MOD;
    end
    return t[PW-1:0];
  endfunction

  // Memory row of a pointer.
  function automatic logic [AW-1:0] ptr_row(logic [PW-1:0] p);
    logic [PW:0] t;
    t = {1'b0, p};
    if (t >= RING) begin
      t = t - RING;
    end
    return t[AW-1:0];
  endfunction

  // Low bits of a fill count as reported on the result.
  function automatic logic [LEVEL_W-1:0] to_level(logic [PW-1:0] f);
    logic [PW+LEVEL_W-1:0] t;
    t = {{LEVEL_W{1'b0}}, f};
    return t[LEVEL_W-1:0];
  endfunction

  // Divide a product by 128, truncating toward zero.
  function automatic logic signed [PCM_W-1:0] scale(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p;
    if (p[PROD_W-1]) begin
      t = p + PROD_W'(127);
    end
    t = t >>> 7;
    return t[PCM_W-1:0];
  endfunction

  // Pointer arithmetic for the request at the head of the queue.
  always_comb begin
    wp_inc          = ptr_inc(wp_r);
    fill_cur        = ptr_sub(wp_r, rp_r);
    fill_push       = ptr_sub(wp_inc, rp_r);
    drop            = ({1'b0, fill_push} >= RING);
    rp_drop         = ptr_sub(wp_inc, HALF[PW-1:0]);
    fill_after_push = drop ? HALF[PW-1:0] : fill_push;
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign q_ready   = (state_r == S_IDLE) && out_free;
  assign take      = q_valid && q_ready;
  assign mem_we    = take && !q_data.is_pop;
  assign gain      = $signed({1'b0, volume});
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result is loaded for a push, a silent pop, or a finished scaled pop.
  assign out_load = (take && (!q_data.is_pop || !play_enable || fill_cur == '0)) ||
                    ((state_r == S_SCALE) && out_free);

  // Frame memory: one write port, one registered read port at the read pointer.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr_row(wp_r)] <= {q_data.left_pcm, q_data.right_pcm};
    end
    rd_data_r <= mem[ptr_row(rp_r)];
  end

  // Sequencer, pointers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Result valid is set on a new result and cleared once it is taken.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            if (!q_data.is_pop) begin
              // Store the frame; on full keep only the newest half.
              wp_r <= wp_inc;
              if (drop) begin
                rp_r <= rp_drop;
              end
              out_data_r.left_out   <= '0;
              out_data_r.right_out  <= '0;
              out_data_r.underrun   <= 1'b0;
              out_data_r.dropped    <= drop;
              out_data_r.fill_level <= to_level(fill_after_push);
            end else if (!play_enable || fill_cur == '0) begin
              // Silence without consuming anything.
              out_data_r.left_out   <= '0;
              out_data_r.right_out  <= '0;
              out_data_r.underrun   <= 1'b1;
              out_data_r.dropped    <= 1'b0;
              out_data_r.fill_level <= to_level(fill_cur);
            end else begin
              rp_r    <= ptr_inc(rp_r);
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          prod_l_r <= $signed(rd_data_r[2*PCM_W-1:PCM_W]) * gain;
          prod_r_r <= $signed(rd_data_r[PCM_W-1:0]) * gain;
          state_r  <= S_SCALE;
        end
        S_SCALE: begin
          if (out_free) begin
            out_data_r.left_out   <= scale(prod_l_r);
            out_data_r.right_out  <= scale(prod_r_r);
            out_data_r.underrun   <= 1'b0;
            out_data_r.dropped    <= 1'b0;
            out_data_r.fill_level <= to_level(fill_cur);
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/pcm_ring_buffer_volume_core.sv */
// Top level of the stereo PCM ring buffer with overwrite and output volume.
`timescale 1ns / 1ps
`default_nettype none

// Stereo PCM ring buffer. A push request carries two fixed-point samples
// (or one mono sample used for both channels); each is rounded, clipped and
// narrowed to 16 bits and the pair is stored as one frame of RING_FRAMES.
// A push that fills the buffer discards the oldest frames so half remain and
// reports dropped. A pop request returns the oldest frame scaled by
// volume/128, or silence with underrun when empty or not enabled. Every
// request gives exactly one result. Requests pass a registered conversion
// stage and a two-entry queue. The back end finishes a push or silent pop from
// idle at one request per cycle while out_stall is low; a pop that reads the
// frame memory passes the registered read and the multiply stage, and no new
// request is taken until it is done. The frame memory needs no clearing after
// reset. The user writes configuration only while idle; the block does not check.
module pcm_ring_buffer_volume_core import prbv_pkg::*; #(
  parameter int RING_FRAMES   = 16384,
  parameter int FRACTION_BITS = 28
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] volume_r;
  logic             play_enable_r;
  logic             fe_valid;
  fe_item_t         fe_data;
  logic             fe_ready;
  logic             q_valid;
  fe_item_t         q_data;
  logic             q_ready;

  // Configuration registers; volume saturates at full gain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r      <= FULL_GAIN;
      play_enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VOLUME: begin
          volume_r <= (cfg_data > FULL_GAIN) ? FULL_GAIN : cfg_data;
        end
        REG_PLAY_ENABLE: begin
          play_enable_r <= cfg_data[0];
        end
        default: begin
          volume_r <= volume_r;
        end
      endcase
    end
  end

  prbv_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .fe_valid (fe_valid),
    .fe_data  (fe_data),
    .fe_ready (fe_ready)
  );

  prbv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_data  (fe_data),
    .push_ready (fe_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop_ready  (q_ready)
  );

  prbv_back #(
    .RING_FRAMES(RING_FRAMES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_ready     (q_ready),
    .volume      (volume_r),
    .play_enable (play_enable_r),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall)
  );

endmodule

`default_nettype wire
